### rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Concurrent checks on the block clock; compiled out when SYNTH is defined.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
// check on every clock edge outside reset
`define ASSERT_CHECK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// check on every clock edge, reset included
`define ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ASSERT_CHECK(lbl, prop, msg)
`define ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

### rtl/tqv_pkg.sv
// ---------------------------------------------------------------------------
// tqv_pkg
// Types, constants and helper functions of the flow Q-vector accumulator.
// ---------------------------------------------------------------------------
package tqv_pkg;

  // sizes
  localparam int DEF_NUM_HARMONICS = 6;
  localparam int MAX_TRACKS        = 65536;
  localparam int CNT_W             = 17;
  localparam int SUM_W             = 48;
  localparam int PROD_W            = 32;
  localparam int TRIG_W            = 16;
  localparam int XY_W              = 18;
  localparam int CORDIC_STEPS      = 15;
  localparam int CORDIC_START      = 9949;
  localparam int TRIG_ONE          = 16384;

  // pipeline positions behind the input register
  localparam int ST_MUL = CORDIC_STEPS + 2;
  localparam int ST_ACC = CORDIC_STEPS + 3;

  // func codes of an input item
  localparam logic [1:0] FUNC_ADD  = 2'd0;
  localparam logic [1:0] FUNC_SUB  = 2'd1;
  localparam logic [1:0] FUNC_EMIT = 2'd2;

  // weight modes
  localparam logic [1:0] MODE_UNIT     = 2'd0;
  localparam logic [1:0] MODE_MOMENTUM = 2'd1;
  localparam logic [1:0] MODE_POSITIVE = 2'd2;
  localparam logic [1:0] MODE_NEGATIVE = 2'd3;

  // register indexes
  localparam logic [1:0] REG_ETA_LOW      = 2'd0;
  localparam logic [1:0] REG_ETA_HIGH     = 2'd1;
  localparam logic [1:0] REG_WEIGHT_MODE  = 2'd2;
  localparam logic [1:0] REG_MOMENTUM_CAP = 2'd3;

  // operation carried down the pipeline
  typedef enum logic [1:0] {
    OP_NONE,
    OP_ADD,
    OP_SUB,
    OP_EMIT
  } op_t;

  typedef struct packed {
    op_t         op;
    logic [15:0] weight;
  } ctl_t;

  // rotation angle of one CORDIC step, in 1/65536 of a turn
  function automatic logic signed [XY_W-1:0] atan_turn(input int step);
    logic signed [XY_W-1:0] r;
    unique case (step)
      0:       r = XY_W'(8192);
      1:       r = XY_W'(4836);
      2:       r = XY_W'(2555);
      3:       r = XY_W'(1297);
      4:       r = XY_W'(651);
      5:       r = XY_W'(326);
      6:       r = XY_W'(163);
      7:       r = XY_W'(81);
      8:       r = XY_W'(41);
      9:       r = XY_W'(20);
      10:      r = XY_W'(10);
      11:      r = XY_W'(5);
      12:      r = XY_W'(3);
      13:      r = XY_W'(1);
      14:      r = XY_W'(1);
      default: r = '0;
    endcase
    return r;
  endfunction

  // limit a CORDIC output to +-1.0 in Q1.14
  function automatic logic signed [TRIG_W-1:0] clamp_trig(input logic signed [XY_W-1:0] v);
    logic signed [TRIG_W-1:0] r;
    if (v > XY_W'(TRIG_ONE)) begin
      r = TRIG_W'(TRIG_ONE);
    end else if (v < -XY_W'(TRIG_ONE)) begin
      r = -TRIG_W'(TRIG_ONE);
    end else begin
      r = v[TRIG_W-1:0];
    end
    return r;
  endfunction

  // accumulator add, saturating at the signed limits
  function automatic logic signed [SUM_W-1:0] sat_add(input logic signed [SUM_W-1:0] s,
                                                      input logic signed [PROD_W-1:0] t);
    logic signed [SUM_W:0]   r;
    logic signed [SUM_W-1:0] q;
    r = {s[SUM_W-1], s} + {{(SUM_W + 1 - PROD_W){t[PROD_W-1]}}, t};
    if (r[SUM_W] != r[SUM_W-1]) begin
      q = r[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
    end else begin
      q = r[SUM_W-1:0];
    end
    return q;
  endfunction

endpackage

### rtl/tqv_track_if.sv
// ---------------------------------------------------------------------------
// tqv_track_if
// Track channel: valid/ready handshake with one track item as payload.
// ---------------------------------------------------------------------------
interface tqv_track_if;
  logic               valid;
  logic               ready;
  logic        [1:0]  func;
  logic        [15:0] angle;
  logic signed [15:0] pseudorapidity;
  logic        [15:0] momentum;
  logic signed [1:0]  charge_sign;
  logic               selected;

  modport source (
    output valid, func, angle, pseudorapidity, momentum, charge_sign, selected,
    input  ready
  );

  modport sink (
    input  valid, func, angle, pseudorapidity, momentum, charge_sign, selected,
    output ready
  );
endinterface

### rtl/tqv_result_if.sv
// ---------------------------------------------------------------------------
// tqv_result_if
// Result channel: valid/ready handshake with one harmonic result as payload.
// ---------------------------------------------------------------------------
interface tqv_result_if;
  logic               valid;
  logic               ready;
  logic        [2:0]  harmonic;
  logic signed [47:0] q_cos;
  logic signed [47:0] q_sin;
  logic        [16:0] tracks_used;
  logic               last;

  modport source (
    output valid, harmonic, q_cos, q_sin, tracks_used, last,
    input  ready
  );

  modport sink (
    input  valid, harmonic, q_cos, q_sin, tracks_used, last,
    output ready
  );
endinterface

### rtl/track_flow_qvector_accumulator.sv
// ---------------------------------------------------------------------------
// track_flow_qvector_accumulator
// Accumulates weighted cos(n phi) / sin(n phi) of tracks for harmonics
// 1..NUM_HARMONICS and returns one result per harmonic on an emit item.
// ---------------------------------------------------------------------------
//  channel  | dir | handshake      | item
//  ---------+-----+----------------+-------------------------------------------
//  track    | in  | valid/ready    | func, angle, eta, momentum, charge, select
//  result   | out | valid/ready    | harmonic, q_cos, q_sin, tracks_used, last
//  APB      | in  | psel/penable   | eta_low, eta_high, weight_mode, mom. cap
//
//  One track item per cycle. A track reaches the accumulators through the
//  input register, angle scaling, 15 CORDIC cells, clamp and multiply.
//  An emit follows the same path, then drains NUM_HARMONICS results from the
//  output buffer, one per cycle while result.ready is high; new tracks flow on.
//  Reset is synchronous; accumulators and track count clear at once.
//  The pipeline halts only when an emit reaches the accumulators while the
//  output buffer still holds results of the previous emit.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module track_flow_qvector_accumulator import tqv_pkg::*; #(
  parameter int NUM_HARMONICS = DEF_NUM_HARMONICS
) (
  input  logic        clk,
  input  logic        rst,
  tqv_track_if.sink   track,
  tqv_result_if.source result,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int IDX_W = $clog2(NUM_HARMONICS + 1);

  logic signed [15:0]      eta_low;
  logic signed [15:0]      eta_high;
  logic        [1:0]       weight_mode;
  logic        [15:0]      momentum_cap;
  logic                    cfg_wr;
  logic                    en;
  logic                    stall;
  logic                    in_take;
  logic                    trk_ok;
  op_t                     op_in;
  logic        [15:0]      weight_in;
  ctl_t                    ctl [0:ST_ACC];
  logic        [15:0]      angle_q;
  logic                    emit_acc;
  logic        [CNT_W-1:0] cnt;
  logic signed [SUM_W-1:0] lane_cos [0:NUM_HARMONICS-1];
  logic signed [SUM_W-1:0] lane_sin [0:NUM_HARMONICS-1];
  logic signed [SUM_W-1:0] buf_cos [0:NUM_HARMONICS-1];
  logic signed [SUM_W-1:0] buf_sin [0:NUM_HARMONICS-1];
  logic        [CNT_W-1:0] buf_cnt;
  logic        [IDX_W-1:0] rem;
  logic        [IDX_W-1:0] idx;
  logic                    out_take;

  // configuration port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      eta_low      <= -16'sd3277;
      eta_high     <= 16'sd3277;
      weight_mode  <= MODE_UNIT;
      momentum_cap <= 16'd512;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        REG_ETA_LOW:      eta_low      <= pwdata[15:0];
        REG_ETA_HIGH:     eta_high     <= pwdata[15:0];
        REG_WEIGHT_MODE:  weight_mode  <= pwdata[1:0];
        REG_MOMENTUM_CAP: momentum_cap <= pwdata[15:0];
        default:          eta_low      <= eta_low;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_ETA_LOW:      prdata = {{16{eta_low[15]}}, eta_low};
      REG_ETA_HIGH:     prdata = {{16{eta_high[15]}}, eta_high};
      REG_WEIGHT_MODE:  prdata = {30'd0, weight_mode};
      REG_MOMENTUM_CAP: prdata = {16'd0, momentum_cap};
      default:          prdata = '0;
    endcase
  end

  // global advance: only an emit blocked by a non-empty output buffer halts
  assign emit_acc    = (ctl[ST_ACC].op == OP_EMIT);
  assign stall       = emit_acc && (rem != '0);
  assign en          = !stall;
  assign track.ready = en;
  assign in_take     = track.valid && track.ready;

  // track selection and weight
  assign trk_ok = (track.pseudorapidity >= eta_low) && (track.pseudorapidity <= eta_high)
               && !((weight_mode == MODE_POSITIVE) && track.charge_sign[1])
               && !((weight_mode == MODE_NEGATIVE) && !track.charge_sign[1]
                    && track.charge_sign[0])
               && track.selected;

  always_comb begin
    if (weight_mode == MODE_MOMENTUM) begin
      weight_in = (track.momentum < momentum_cap) ? track.momentum : momentum_cap;
    end else begin
      weight_in = 16'd1;
    end
  end

  always_comb begin
    op_in = OP_NONE;
    if (in_take) begin
      unique case (track.func)
        FUNC_ADD:  op_in = trk_ok ? OP_ADD : OP_NONE;
        FUNC_SUB:  op_in = trk_ok ? OP_SUB : OP_NONE;
        FUNC_EMIT: op_in = OP_EMIT;
        default:   op_in = OP_NONE;
      endcase
    end
  end

  // control shift line alongside the lanes
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k <= ST_ACC; k++) begin
        ctl[k] <= '{op: OP_NONE, weight: '0};
      end
    end else if (en) begin
      ctl[0] <= '{op: op_in, weight: weight_in};
      for (int k = 0; k < ST_ACC; k++) begin
        ctl[k+1] <= ctl[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      angle_q <= track.angle;
    end
  end

  // one lane per harmonic
  for (genvar h = 0; h < NUM_HARMONICS; h++) begin : g_lane
    tqv_lane #(.HARM(h + 1)) u_lane (
      .clk    (clk),
      .rst    (rst),
      .en     (en),
      .angle  (angle_q),
      .weight (ctl[ST_MUL].weight),
      .op     (ctl[ST_ACC].op),
      .q_cos  (lane_cos[h]),
      .q_sin  (lane_sin[h])
    );
  end

  // added-track count, saturating, cleared on emit
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (en) begin
      if (emit_acc) begin
        cnt <= '0;
      end else if ((ctl[ST_ACC].op == OP_ADD) && (cnt < CNT_W'(MAX_TRACKS))) begin
        cnt <= cnt + 1'b1;
      end
    end
  end

  // output buffer: snapshot on emit, shifted out one harmonic per item
  assign out_take = result.valid && result.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      rem <= '0;
      idx <= '0;
    end else if (en && emit_acc) begin
      rem <= IDX_W'(NUM_HARMONICS);
      idx <= '0;
    end else if (out_take) begin
      rem <= rem - 1'b1;
      idx <= idx + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (en && emit_acc) begin
      for (int k = 0; k < NUM_HARMONICS; k++) begin
        buf_cos[k] <= lane_cos[k];
        buf_sin[k] <= lane_sin[k];
      end
      buf_cnt <= cnt;
    end else if (out_take) begin
      for (int k = 0; k < NUM_HARMONICS - 1; k++) begin
        buf_cos[k] <= buf_cos[k+1];
        buf_sin[k] <= buf_sin[k+1];
      end
    end
  end

  assign result.valid       = (rem != '0);
  assign result.harmonic    = 3'(32'(idx) + 1);
  assign result.q_cos       = buf_cos[0];
  assign result.q_sin       = buf_sin[0];
  assign result.tracks_used = buf_cnt;
  assign result.last        = (rem == IDX_W'(1));

  // checks
  `ASSERT_ALWAYS(a_reset_empty, (rst |=> !result.valid), "output not empty after reset")
  `ASSERT_CHECK(a_snap_empty, ((en && emit_acc) |-> (rem == '0)), "emit over live buffer")
  `ASSERT_CHECK(a_last_drains, ((out_take && result.last) |=> !result.valid), "extra result")
  `ASSERT_CHECK(a_idx_rem, (result.valid |-> ((32'(idx) + 32'(rem)) == NUM_HARMONICS)), "index slip")
  `ASSERT_CHECK(a_cnt_clear, ((en && emit_acc) |=> (cnt == '0)), "count not cleared on emit")

endmodule

### rtl/tqv_cordic_cell.sv
// ---------------------------------------------------------------------------
// tqv_cordic_cell
// One rotation step of the CORDIC chain, registered towards the next cell.
// ---------------------------------------------------------------------------
module tqv_cordic_cell import tqv_pkg::*; #(
  parameter int STEP = 0
) (
  input  logic                   clk,
  input  logic                   en,
  input  logic signed [XY_W-1:0] x_in,
  input  logic signed [XY_W-1:0] y_in,
  input  logic signed [XY_W-1:0] z_in,
  output logic signed [XY_W-1:0] x,
  output logic signed [XY_W-1:0] y,
  output logic signed [XY_W-1:0] z
);

  logic signed [XY_W-1:0] dx;
  logic signed [XY_W-1:0] dy;
  logic signed [XY_W-1:0] rot;

  // floor shifts of the opposite coordinate
  assign dx  = y_in >>> STEP;
  assign dy  = x_in >>> STEP;
  assign rot = atan_turn(STEP);

  // turn towards zero residual angle
  always_ff @(posedge clk) begin
    if (en) begin
      if (!z_in[XY_W-1]) begin
        x <= x_in - dx;
        y <= y_in + dy;
        z <= z_in - rot;
      end else begin
        x <= x_in + dx;
        y <= y_in - dy;
        z <= z_in + rot;
      end
    end
  end

endmodule

### rtl/tqv_lane.sv
// ---------------------------------------------------------------------------
// tqv_lane
// One harmonic: angle scaling, CORDIC cell chain, weight multiply and the
// saturating cos/sin accumulators.
// ---------------------------------------------------------------------------
module tqv_lane import tqv_pkg::*; #(
  parameter int HARM = 1
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    en,
  input  logic [15:0]             angle,
  input  logic [15:0]             weight,
  input  op_t                     op,
  output logic signed [SUM_W-1:0] q_cos,
  output logic signed [SUM_W-1:0] q_sin
);

  logic        [15:0]       ang_n;
  logic                     flip;
  logic        [15:0]       ang_rot;
  logic signed [XY_W-1:0]   z_pre;
  logic signed [XY_W-1:0]   z0;
  logic                     flip_d [0:CORDIC_STEPS];
  logic signed [XY_W-1:0]   x_c [0:CORDIC_STEPS];
  logic signed [XY_W-1:0]   y_c [0:CORDIC_STEPS];
  logic signed [XY_W-1:0]   z_c [0:CORDIC_STEPS];
  logic signed [TRIG_W-1:0] cl_cos;
  logic signed [TRIG_W-1:0] cl_sin;
  logic signed [TRIG_W-1:0] c_q;
  logic signed [TRIG_W-1:0] s_q;
  logic signed [16:0]       w_s;
  logic signed [32:0]       prod_c;
  logic signed [32:0]       prod_s;
  logic signed [PROD_W-1:0] p_cos;
  logic signed [PROD_W-1:0] p_sin;
  logic signed [PROD_W-1:0] term_cos;
  logic signed [PROD_W-1:0] term_sin;

  // n*phi mod one turn; left half-plane is turned by half a turn
  assign ang_n   = 16'(angle * HARM);
  assign flip    = ang_n[15] ^ ang_n[14];
  assign ang_rot = {ang_n[15] ^ flip, ang_n[14:0]};
  assign z_pre   = XY_W'(signed'(ang_rot));

  always_ff @(posedge clk) begin
    if (en) begin
      z0        <= z_pre;
      flip_d[0] <= flip;
      for (int k = 0; k < CORDIC_STEPS; k++) begin
        flip_d[k+1] <= flip_d[k];
      end
    end
  end

  // rotation chain
  assign x_c[0] = XY_W'(CORDIC_START);
  assign y_c[0] = '0;
  assign z_c[0] = z0;

  for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_cell
    tqv_cordic_cell #(.STEP(k)) u_cell (
      .clk  (clk),
      .en   (en),
      .x_in (x_c[k]),
      .y_in (y_c[k]),
      .z_in (z_c[k]),
      .x    (x_c[k+1]),
      .y    (y_c[k+1]),
      .z    (z_c[k+1])
    );
  end

  // clamp and undo the half turn
  assign cl_cos = clamp_trig(x_c[CORDIC_STEPS]);
  assign cl_sin = clamp_trig(y_c[CORDIC_STEPS]);

  always_ff @(posedge clk) begin
    if (en) begin
      c_q <= flip_d[CORDIC_STEPS] ? -cl_cos : cl_cos;
      s_q <= flip_d[CORDIC_STEPS] ? -cl_sin : cl_sin;
    end
  end

  // weight times trig
  assign w_s    = signed'({1'b0, weight});
  assign prod_c = w_s * c_q;
  assign prod_s = w_s * s_q;

  always_ff @(posedge clk) begin
    if (en) begin
      p_cos <= prod_c[PROD_W-1:0];
      p_sin <= prod_s[PROD_W-1:0];
    end
  end

  // accumulate, subtract or clear
  assign term_cos = (op == OP_SUB) ? -p_cos : p_cos;
  assign term_sin = (op == OP_SUB) ? -p_sin : p_sin;

  always_ff @(posedge clk) begin
    if (rst) begin
      q_cos <= '0;
      q_sin <= '0;
    end else if (en) begin
      unique case (op)
        OP_ADD, OP_SUB: begin
          q_cos <= sat_add(q_cos, term_cos);
          q_sin <= sat_add(q_sin, term_sin);
        end
        OP_EMIT: begin
          q_cos <= '0;
          q_sin <= '0;
        end
        default: begin
          q_cos <= q_cos;
          q_sin <= q_sin;
        end
      endcase
    end
  end

endmodule
